// File: hw/rtl/nph_pkg.sv
// ----------------------------------------------------------------------------
// nph_pkg
// Types, codes and digit tables for the natural path compare block.
// ----------------------------------------------------------------------------
package nph_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned WeightW = 9;
  localparam int unsigned OrderW = 10;
  localparam int unsigned DsW    = 4;

  localparam logic [CharW-1:0] SepReset = 8'd47;
  localparam logic [CharW-1:0] CharZero = 8'h30;
  localparam logic [CharW-1:0] CharNine = 8'h39;

  // digit machine states
  localparam logic [DsW-1:0] DsNormal = 4'h0;
  localparam logic [DsW-1:0] DsInt    = 4'h3;
  localparam logic [DsW-1:0] DsFrac   = 4'h6;
  localparam logic [DsW-1:0] DsZero   = 4'h9;

  // digit classes
  localparam logic [1:0] ClsOther = 2'd0;
  localparam logic [1:0] ClsNz    = 2'd1;
  localparam logic [1:0] ClsZero  = 2'd2;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_CMP  = 2'd1,
    PH_RUN  = 2'd2,
    PH_DONE = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    ACT_WEIGHT = 2'd0,
    ACT_RUNLEN = 2'd1,
    ACT_NEG    = 2'd2,
    ACT_POS    = 2'd3
  } act_e;

  typedef struct packed {
    phase_e                    phase;
    logic [DsW-1:0]            base;
    logic signed [OrderW-1:0]  saved;
  } nph_state_t;

  function automatic logic is_digit(input logic [CharW-1:0] v);
    return (v >= CharZero) && (v <= CharNine);
  endfunction

  function automatic logic [1:0] digit_class(input logic [CharW-1:0] v);
    logic [1:0] c;
    c = ClsOther;
    if (v == CharZero) begin
      c = ClsZero;
    end else if (is_digit(v)) begin
      c = ClsNz;
    end
    return c;
  endfunction

  function automatic logic [WeightW-1:0] byte_weight(input logic [CharW-1:0] v,
                                                     input logic [CharW-1:0] sep);
    logic [WeightW-1:0] w;
    if (v == '0) begin
      w = '0;
    end else if (v == sep) begin
      w = WeightW'(1);
    end else begin
      w = {1'b0, v} + WeightW'(1);
    end
    return w;
  endfunction

  // next digit state after an equal pair
  function automatic logic [DsW-1:0] advance(input logic [DsW-1:0] st);
    logic [DsW-1:0] n;
    unique case (st)
      4'd0, 4'd3, 4'd6, 4'd9: n = DsNormal;
      4'd1, 4'd4, 4'd5:       n = DsInt;
      4'd2, 4'd11:            n = DsZero;
      4'd7, 4'd8, 4'd10:      n = DsFrac;
      default:                n = DsNormal;
    endcase
    return n;
  endfunction

  // action at the first differing pair
  function automatic act_e decide(input logic [DsW-1:0] st, input logic [1:0] cls_b);
    act_e a;
    a = ACT_WEIGHT;
    unique case (st)
      4'd1:         a = (cls_b == ClsNz) ? ACT_RUNLEN : ACT_WEIGHT;
      4'd3:         a = (cls_b == ClsOther) ? ACT_WEIGHT : ACT_NEG;
      4'd4, 4'd5:   a = (cls_b == ClsOther) ? ACT_POS : ACT_RUNLEN;
      4'd9:         a = (cls_b == ClsOther) ? ACT_WEIGHT : ACT_POS;
      4'd10, 4'd11: a = (cls_b == ClsOther) ? ACT_NEG : ACT_WEIGHT;
      default:      a = ACT_WEIGHT;
    endcase
    return a;
  endfunction

endpackage

// File: hw/rtl/nph_step.sv
// ----------------------------------------------------------------------------
// nph_step
// Next state and result for one character pair word.
// ----------------------------------------------------------------------------
module nph_step import nph_pkg::*; (
  input  nph_state_t               state_i,
  input  logic                     start_i,
  input  logic [CharW-1:0]         char_a_i,
  input  logic [CharW-1:0]         char_b_i,
  input  logic [CharW-1:0]         sep_i,
  output nph_state_t               state_o,
  output logic                     emit_o,
  output logic signed [OrderW-1:0] order_o
);

  nph_state_t               cur;
  logic [1:0]               cls_a;
  logic [1:0]               cls_b;
  logic [DsW-1:0]           st;
  logic signed [OrderW-1:0] diff;
  act_e                     act;

  function automatic logic signed [OrderW-1:0] sbit1();
    return OrderW'(1);
  endfunction

  always_comb begin
    cur = state_i;
    if (start_i) begin
      cur.phase = PH_CMP;
      cur.base  = DsNormal;
      cur.saved = '0;
    end
    cls_a = digit_class(char_a_i);
    cls_b = digit_class(char_b_i);
    st    = cur.base + DsW'(cls_a);
    diff  = $signed({1'b0, byte_weight(char_a_i, sep_i)})
          - $signed({1'b0, byte_weight(char_b_i, sep_i)});
    act   = decide(st, cls_b);

    state_o = cur;
    emit_o  = 1'b0;
    order_o = '0;

    unique case (cur.phase)
      PH_CMP: begin
        if (diff == '0) begin
          if (char_a_i == '0) begin
            emit_o        = 1'b1;
            state_o.phase = PH_DONE;
          end else begin
            state_o.base = advance(st);
          end
        end else begin
          unique case (act)
            ACT_WEIGHT: begin
              emit_o        = 1'b1;
              order_o       = diff;
              state_o.phase = PH_DONE;
            end
            ACT_RUNLEN: begin
              state_o.saved = diff;
              state_o.phase = PH_RUN;
            end
            ACT_NEG: begin
              emit_o        = 1'b1;
              order_o       = -OrderW'(sbit1());
              state_o.phase = PH_DONE;
            end
            ACT_POS: begin
              emit_o        = 1'b1;
              order_o       = OrderW'(sbit1());
              state_o.phase = PH_DONE;
            end
            default: ;
          endcase
        end
      end
      PH_RUN: begin
        if (is_digit(char_a_i)) begin
          if (!is_digit(char_b_i)) begin
            emit_o        = 1'b1;
            order_o       = OrderW'(sbit1());
            state_o.phase = PH_DONE;
          end
        end else begin
          emit_o        = 1'b1;
          order_o       = is_digit(char_b_i) ? -OrderW'(sbit1()) : cur.saved;
          state_o.phase = PH_DONE;
        end
      end
      default: ;
    endcase
  end

endmodule

// File: hw/rtl/natural_path_compare.sv
// ----------------------------------------------------------------------------
// natural_path_compare
// Streaming version-style compare of two strings, one character pair a word.
// ----------------------------------------------------------------------------
// Each input word carries the bytes at one position of both strings; a word
// with start_compare_i set opens a new comparison. One order word comes out
// per comparison once it is decided, and words after that are dropped until
// the next start. One word is accepted every cycle while the output is free:
// the input register feeds the digit machine and decision logic, which loads
// the result register in the same cycle. While an order word waits at the
// output, a word in the input register waits too, and the input stalls once
// that register is full. The user writes the separator register through
// cfg_we_i while the block is idle; the block does not enforce this.
module natural_path_compare import nph_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CharW-1:0]         cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     start_compare_i,
  input  logic [CharW-1:0]         char_a_i,
  input  logic [CharW-1:0]         char_b_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [OrderW-1:0] order_o
);

  logic [CharW-1:0]         sep_q;
  logic                     in_valid_q;
  logic                     start_q;
  logic [CharW-1:0]         char_a_q;
  logic [CharW-1:0]         char_b_q;
  nph_state_t               state_q, state_d;
  logic                     out_valid_q;
  logic signed [OrderW-1:0] order_q;
  logic                     emit;
  logic signed [OrderW-1:0] order_d;
  logic                     consume;

  assign consume    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || consume;

  nph_step u_step (
    .state_i  (state_q),
    .start_i  (start_q),
    .char_a_i (char_a_q),
    .char_b_i (char_b_q),
    .sep_i    (sep_q),
    .state_o  (state_d),
    .emit_o   (emit),
    .order_o  (order_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_q       <= SepReset;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '{phase: PH_IDLE, base: DsNormal, saved: '0};
    end else begin
      if (cfg_we_i) begin
        sep_q <= cfg_wdata_i;
      end
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (consume) begin
        state_q <= state_d;
      end
      if (consume) begin
        out_valid_q <= emit || (out_valid_q && !out_ready_i);
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      start_q  <= start_compare_i;
      char_a_q <= char_a_i;
      char_b_q <= char_b_i;
    end
    if (consume && emit) begin
      order_q <= order_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign order_o     = order_q;

endmodule

// File: tb/natural_path_compare_checker.sv
// ----------------------------------------------------------------------------
// natural_path_compare_checker
// Watches both channels and the separator port of the compare block, works
// out the order word each accepted character pair should produce from its own
// copy of the digit machine, and checks every accepted order word in turn.
// ----------------------------------------------------------------------------
module natural_path_compare_checker import nph_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CharW-1:0]         cfg_wdata_i,
  input  logic                     in_valid_i,
  input  logic                     in_ready_i,
  input  logic                     start_compare_i,
  input  logic [CharW-1:0]         char_a_i,
  input  logic [CharW-1:0]         char_b_i,
  input  logic                     out_valid_i,
  input  logic                     out_ready_i,
  input  logic signed [OrderW-1:0] order_i,
  output int unsigned              fail_count_o,
  output int unsigned              pending_o,
  output int unsigned              live_words_o
);

  logic [CharW-1:0]         sep_q;
  phase_e                   phase_q;
  logic [DsW-1:0]           base_q;
  logic signed [OrderW-1:0] saved_q;
  logic signed [OrderW-1:0] due_orders[$];
  int unsigned              fails = 0;
  int unsigned              live_words = 0;

  assign fail_count_o = fails;
  assign pending_o    = due_orders.size();
  assign live_words_o = live_words;

  function automatic logic is_num(input logic [CharW-1:0] c);
    return (c >= CharZero) && (c <= CharNine);
  endfunction

  function automatic logic [1:0] class_of(input logic [CharW-1:0] c);
    if (c == CharZero) return ClsZero;
    if (is_num(c)) return ClsNz;
    return ClsOther;
  endfunction

  function automatic int weight_of(input logic [CharW-1:0] c);
    if (c == '0) return 0;
    if (c == sep_q) return 1;
    return int'(c) + 1;
  endfunction

  // digit state carried past a pair of equal characters
  function automatic logic [DsW-1:0] base_after(input logic [DsW-1:0] st);
    case (st)
      4'd1, 4'd4, 4'd5:  return DsInt;
      4'd7, 4'd8, 4'd10: return DsFrac;
      4'd2, 4'd11:       return DsZero;
      default:           return DsNormal;
    endcase
  endfunction

  // outcome at the first pair whose weights differ
  function automatic act_e verdict_at(input logic [DsW-1:0] st, input logic [1:0] cls_b);
    logic b_other;
    b_other = (cls_b == ClsOther);
    case (st)
      4'd1:         return (cls_b == ClsNz) ? ACT_RUNLEN : ACT_WEIGHT;
      4'd3:         return b_other ? ACT_WEIGHT : ACT_NEG;
      4'd4, 4'd5:   return b_other ? ACT_POS : ACT_RUNLEN;
      4'd9:         return b_other ? ACT_WEIGHT : ACT_POS;
      4'd10, 4'd11: return b_other ? ACT_NEG : ACT_WEIGHT;
      default:      return ACT_WEIGHT;
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    fails++;
    if (fails <= 100) $display("[check] %s", what);
  endtask

  task automatic settle_order(input int v);
    due_orders.push_back(OrderW'(v));
    phase_q = PH_DONE;
  endtask

  task automatic compare_step(input logic s, input logic [CharW-1:0] a,
                              input logic [CharW-1:0] b);
    logic [DsW-1:0] st;
    int             diff;
    if (s) begin
      phase_q = PH_CMP;
      base_q  = DsNormal;
      saved_q = '0;
    end
    live_words++;
    case (phase_q)
      PH_CMP: begin
        st   = base_q + DsW'(class_of(a));
        diff = weight_of(a) - weight_of(b);
        if (diff == 0) begin
          if (a == '0) settle_order(0);
          else base_q = base_after(st);
        end else begin
          case (verdict_at(st, class_of(b)))
            ACT_WEIGHT: settle_order(diff);
            ACT_NEG:    settle_order(-1);
            ACT_POS:    settle_order(1);
            default: begin
              saved_q = OrderW'(diff);
              phase_q = PH_RUN;
            end
          endcase
        end
      end
      PH_RUN: begin
        if (is_num(a)) begin
          if (!is_num(b)) settle_order(1);
        end else begin
          settle_order(is_num(b) ? -1 : int'(saved_q));
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    logic signed [OrderW-1:0] want;
    if (!rst_ni) begin
      sep_q   = SepReset;
      phase_q = PH_IDLE;
      base_q  = DsNormal;
      saved_q = '0;
      due_orders.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (due_orders.size() == 0) begin
          report_mismatch($sformatf("unexpected order word %0d", order_i));
        end else begin
          want = due_orders.pop_front();
          if (order_i !== want)
            report_mismatch($sformatf("order got %0d, want %0d", order_i, want));
        end
      end
      if (in_valid_i && in_ready_i) compare_step(start_compare_i, char_a_i, char_b_i);
      if (cfg_we_i) sep_q = cfg_wdata_i;
    end
  end

endmodule

// File: tb/natural_path_compare_tb.sv
// ----------------------------------------------------------------------------
// natural_path_compare_tb
// Streams directed and random string pairs through the compare block under
// several separator values and idle patterns, and gives the final verdict.
// ----------------------------------------------------------------------------
module natural_path_compare_tb;
  import nph_pkg::*;

  localparam int unsigned TotalWords  = 1650;
  localparam int unsigned Phases      = 8;
  localparam int unsigned HoldCycles  = 80;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned CycleLimit  = 600000;
  localparam int unsigned StrDepth    = 16;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     cfg_we = 1'b0;
  logic [CharW-1:0]         cfg_wdata = '0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic                     start_compare = 1'b0;
  logic [CharW-1:0]         char_a = '0;
  logic [CharW-1:0]         char_b = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [OrderW-1:0] order;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned live_words;

  int unsigned      idle_pct = 0;
  int unsigned      stall_pct = 0;
  int unsigned      hold_req = 0;
  int unsigned      hold_ack = 0;
  int unsigned      hold_left = 0;
  int unsigned      cycle_count = 0;
  logic [CharW-1:0] cur_sep = SepReset;
  logic [CharW-1:0] str_a [StrDepth];
  logic [CharW-1:0] str_b [StrDepth];

  natural_path_compare dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .start_compare_i(start_compare),
    .char_a_i       (char_a),
    .char_b_i       (char_b),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .order_o        (order)
  );

  natural_path_compare_checker u_check (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .start_compare_i(start_compare),
    .char_a_i       (char_a),
    .char_b_i       (char_b),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .order_i        (order),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .live_words_o   (live_words)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("natural_path_compare: mismatch");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left <= 0;
    end else if (hold_ack != hold_req) begin
      hold_ack  <= hold_req;
      hold_left <= HoldCycles;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  task automatic send_word(input logic s, input logic [CharW-1:0] a,
                           input logic [CharW-1:0] b);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    start_compare <= s;
    char_a        <= a;
    char_b        <= b;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
  endtask

  task automatic feed_strings(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) send_word(i == 0, str_a[i], str_b[i]);
  endtask

  task automatic compare_text(input string sa, input string sb);
    int unsigned n;
    n = ((sa.len() > sb.len()) ? sa.len() : sb.len()) + 1;
    for (int i = 0; i < StrDepth; i++) begin
      str_a[i] = (i < sa.len()) ? sa[i] : 8'h00;
      str_b[i] = (i < sb.len()) ? sb[i] : 8'h00;
    end
    feed_strings(n);
  endtask

  function automatic logic [CharW-1:0] pick_char();
    case ($urandom_range(0, 15))
      0, 1, 2, 3, 4, 5: return CharZero + CharW'($urandom_range(0, 9));
      6, 7:             return CharZero;
      8:                return (cur_sep == '0) ? 8'h2e : cur_sep;
      9:                return 8'h2e;
      10:               return 8'h61 + CharW'($urandom_range(0, 25));
      11:               return CharW'($urandom_range(1, 255));
      12:               return CharNine;
      13:               return 8'h31;
      14:               return 8'h2d;
      default:          return CharW'($urandom_range(128, 255));
    endcase
  endfunction

  task automatic random_compare();
    int unsigned la;
    int unsigned lb;
    int unsigned n;
    la = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 14) : $urandom_range(0, 8);
    lb = la;
    for (int i = 0; i < StrDepth; i++) begin
      str_a[i] = '0;
      str_b[i] = '0;
    end
    for (int unsigned i = 0; i < la; i++) str_a[i] = pick_char();
    case ($urandom_range(0, 3))
      0: for (int unsigned i = 0; i < la; i++) str_b[i] = str_a[i];
      1: begin
        for (int unsigned i = 0; i < la; i++) str_b[i] = str_a[i];
        if (la > 0) str_b[$urandom_range(0, la - 1)] = pick_char();
      end
      2: begin
        lb = $urandom_range(0, (la + 2 > 14) ? 14 : la + 2);
        for (int unsigned i = 0; i < lb; i++) str_b[i] = (i < la) ? str_a[i] : pick_char();
      end
      default: begin
        lb = $urandom_range(0, 8);
        for (int unsigned i = 0; i < lb; i++) str_b[i] = pick_char();
      end
    endcase
    n = ((la > lb) ? la : lb) + 1;
    // cut some sequences short so the next start drops them
    if ($urandom_range(0, 9) == 0) n = $urandom_range(1, n);
    feed_strings(n);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_separator(input logic [CharW-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    cur_sep   = v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    logic [CharW-1:0] sep_val;
    int unsigned      target;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(1'b1, 8'h00, 8'h00);
    send_word(1'b1, 8'hff, 8'h00);
    send_word(1'b1, 8'h00, 8'hff);
    send_word(1'b0, 8'h55, 8'h55);
    compare_text("/", "a");
    compare_text("12", "9");
    compare_text("00", "0");
    compare_text("9a", "12");
    compare_text("3x", "1y");
    compare_text("123", "456");
    send_word(1'b1, 8'h61, 8'h61);
    send_word(1'b1, 8'h62, 8'h63);

    for (int unsigned p = 0; p < Phases; p++) begin
      wait_idle();
      case (p)
        0:       sep_val = SepReset;
        1:       sep_val = 8'h00;
        2:       sep_val = 8'hff;
        3:       sep_val = CharZero;
        4:       sep_val = 8'h2e;
        5:       sep_val = CharW'($urandom_range(1, 254));
        6:       sep_val = CharNine;
        default: sep_val = 8'h01;
      endcase
      write_separator(sep_val);
      case (p % 4)
        0: begin
          idle_pct  = 0;
          stall_pct <= 0;
          hold_req  <= hold_req + 1;
        end
        1: begin
          idle_pct  = 72;
          stall_pct <= 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct <= 72;
        end
        default: begin
          idle_pct  = 34;
          stall_pct <= 34;
        end
      endcase
      target = (p + 1) * TotalWords / Phases;
      while (live_words < target) begin
        if ($urandom_range(0, 9) < 8) begin
          random_compare();
        end else begin
          send_word($urandom_range(0, 3) == 0, CharW'($urandom_range(0, 255)),
                    CharW'($urandom_range(0, 255)));
        end
      end
    end
    wait_idle();

    if (fail_count == 0) begin
      $display("natural_path_compare: match");
    end else begin
      $display("natural_path_compare: mismatch");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/nph_pkg.sv
hw/rtl/nph_step.sv
hw/rtl/natural_path_compare.sv
tb/natural_path_compare_checker.sv
tb/natural_path_compare_tb.sv
